// ===== rtl/sm4_pkg.sv =====
package sm4_pkg;

    typedef logic [31:0] word_t;
    typedef logic [31:0][31:0] rk_bank_t;   // index = round number

    // APB register indexes (paddr[3] selects the register)
    localparam logic REG_KEY_UPPER = 1'b0;
    localparam logic REG_KEY_LOWER = 1'b1;

    localparam word_t FK0 = 32'ha3b1bac6;
    localparam word_t FK1 = 32'h56aa3350;
    localparam word_t FK2 = 32'h677d9197;
    localparam word_t FK3 = 32'hb27022dc;

    localparam logic [7:0] SBOX [256] = '{
        8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
        8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
        8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
        8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
        8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
        8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
        8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
        8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
        8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
        8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
        8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
        8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
        8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
        8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
        8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
        8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
    };

    // byte-wise S-box substitution
    function automatic word_t tau(input word_t a);
        return {SBOX[a[31:24]], SBOX[a[23:16]], SBOX[a[15:8]], SBOX[a[7:0]]};
    endfunction

    // data-path linear map: t ^ t<<<2 ^ t<<<10 ^ t<<<18 ^ t<<<24
    function automatic word_t l_data(input word_t t);
        return t ^ {t[29:0], t[31:30]} ^ {t[21:0], t[31:22]}
                 ^ {t[13:0], t[31:14]} ^ {t[7:0], t[31:8]};
    endfunction

    // key schedule linear map: t ^ t<<<13 ^ t<<<23
    function automatic word_t l_key(input word_t t);
        return t ^ {t[18:0], t[31:19]} ^ {t[8:0], t[31:9]};
    endfunction

    // CK byte j of round i is (4i+j)*7 mod 256, most significant byte first
    function automatic word_t ck_word(input logic [4:0] i);
        logic [7:0] b;
        word_t      w;
        w = '0;
        for (int j = 0; j < 4; j++) begin
            b = {1'b0, i, 2'(j)};
            w = {w[23:0], 8'((b << 3) - b)};
        end
        return w;
    endfunction

endpackage

// ===== rtl/sm4_key_sched.sv =====
module sm4_key_sched (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start_i,   // key register written: re-expand
    input  logic [127:0]      key_i,
    output logic              busy_o,
    output sm4_pkg::rk_bank_t rk_o
);

    typedef enum logic [1:0] {KS_IDLE, KS_LOAD, KS_RUN} ks_state_t;

    ks_state_t              state_reg, state_next;
    logic [4:0]             cnt_reg, cnt_next;
    sm4_pkg::word_t [3:0]   k_reg, k_next;      // k_reg[0] is the oldest word
    sm4_pkg::rk_bank_t      rk_reg, rk_next;
    sm4_pkg::word_t         t_w;
    sm4_pkg::word_t         n_w;

    assign t_w = sm4_pkg::tau(k_reg[1] ^ k_reg[2] ^ k_reg[3] ^ sm4_pkg::ck_word(cnt_reg));
    assign n_w = k_reg[0] ^ sm4_pkg::l_key(t_w);

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        k_next     = k_reg;
        rk_next    = rk_reg;
        case (state_reg)
            KS_IDLE: begin
            end
            KS_LOAD: begin
                k_next[0]  = key_i[127:96] ^ sm4_pkg::FK0;
                k_next[1]  = key_i[95:64]  ^ sm4_pkg::FK1;
                k_next[2]  = key_i[63:32]  ^ sm4_pkg::FK2;
                k_next[3]  = key_i[31:0]   ^ sm4_pkg::FK3;
                cnt_next   = '0;
                state_next = KS_RUN;
            end
            KS_RUN: begin
                k_next  = {n_w, k_reg[3], k_reg[2], k_reg[1]};
                // shift in from the top: after 32 rounds entry 0 holds round 0
                rk_next = {n_w, rk_reg[31:1]};
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'd31) begin
                    state_next = KS_IDLE;
                end
            end
            default: begin
                state_next = KS_LOAD;
            end
        endcase
        if (start_i) begin
            state_next = KS_LOAD;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= KS_LOAD;   // expand the all-zero key after reset
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
        k_reg  <= k_next;
        rk_reg <= rk_next;
    end

    assign busy_o = (state_reg != KS_IDLE);
    assign rk_o   = rk_reg;

endmodule

// ===== rtl/sm4_block_cipher_core.sv =====
// SM4 block cipher core, ECB, one 128-bit block per word.
// Pipeline: one round per register stage, from input acceptance to m_tvalid.
// Throughput: one block per cycle, sustained while m_tready stays high and
// no key write or expansion is under way. Key expansion: runs after reset or
// after a key register write, one key round per cycle, with s_tready low.
// Reset (aresetn, synchronous, active low) zeroes the key and empties the pipe.
module sm4_block_cipher_core (
    input  logic         aclk,
    input  logic         aresetn,

    // APB configuration port
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [63:0]  pwdata,
    output logic [63:0]  prdata,
    output logic         pready,

    // input blocks
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [127:0] s_tdata,   // [63:0] block_upper, [127:64] block_lower
    input  logic         s_tuser,   // [0] command (0 encrypt, 1 decrypt)

    // results
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata    // [63:0] result_upper, [127:64] result_lower
);

    localparam int NR = 32;

    // ---------------------------------------------------------------------
    // Key registers. paddr[3] picks the register, so byte 0 is key_upper
    // and byte 8 is key_lower; pready is tied high.
    // ---------------------------------------------------------------------
    logic [63:0] key_upper_reg;
    logic [63:0] key_lower_reg;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_upper_reg <= '0;
            key_lower_reg <= '0;
        end else if (cfg_wr) begin
            if (paddr[3] == sm4_pkg::REG_KEY_UPPER) begin
                key_upper_reg <= pwdata;
            end else begin
                key_lower_reg <= pwdata;
            end
        end
    end

    assign prdata = (paddr[3] == sm4_pkg::REG_KEY_UPPER) ? key_upper_reg : key_lower_reg;

    // ---------------------------------------------------------------------
    // Round key expansion: sequential, one key round per cycle, keys kept
    // in a register bank; each stage taps it at a place set by its command.
    // ---------------------------------------------------------------------
    logic              ks_busy;
    sm4_pkg::rk_bank_t rk;

    sm4_key_sched u_key_sched (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start_i (cfg_wr),
        .key_i   ({key_upper_reg, key_lower_reg}),
        .busy_o  (ks_busy),
        .rk_o    (rk)
    );

    // ---------------------------------------------------------------------
    // Data pipeline: 32 unrolled rounds, one register stage each. Stage i
    // holds the state after round i as {x0, x1, x2, x3}, x0 in the top word.
    // The whole pipe moves together; it stalls only when the last stage
    // holds a word that the sink has not taken.
    // ---------------------------------------------------------------------
    logic [127:0]  st_reg  [NR];
    logic [127:0]  st_next [NR];
    logic [NR-1:0] cmd_reg;
    logic [NR-1:0] vld_reg;
    logic          advance;
    logic          s_accept;
    logic [127:0]  st_in;

    assign advance  = !vld_reg[NR-1] || m_tready;
    assign s_tready = advance && !ks_busy && !cfg_wr;
    assign s_accept = s_tvalid && s_tready;

    // x0 = block_upper[63:32], x1 = block_upper[31:0], x2/x3 from block_lower
    assign st_in = {s_tdata[63:32], s_tdata[31:0], s_tdata[127:96], s_tdata[95:64]};

    for (genvar i = 0; i < NR; i++) begin : g_round
        logic [127:0]   x_w;
        logic           cmd_w;
        sm4_pkg::word_t rk_w;
        sm4_pkg::word_t t_w;

        if (i == 0) begin : g_first
            assign x_w   = st_in;
            assign cmd_w = s_tuser;
        end else begin : g_rest
            assign x_w   = st_reg[i-1];
            assign cmd_w = cmd_reg[i-1];
        end

        // decryption walks the round keys backwards
        assign rk_w = cmd_w ? rk[NR-1-i] : rk[i];
        assign t_w  = sm4_pkg::tau(x_w[95:64] ^ x_w[63:32] ^ x_w[31:0] ^ rk_w);

        always_comb begin
            st_next[i] = {x_w[95:0], x_w[127:96] ^ sm4_pkg::l_data(t_w)};
        end

        always_ff @(posedge aclk) begin
            if (advance) begin
                st_reg[i]  <= st_next[i];
                cmd_reg[i] <= cmd_w;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (advance) begin
            vld_reg <= {vld_reg[NR-2:0], s_accept};
        end
    end

    // result is {x3, x2} then {x1, x0}
    assign m_tvalid = vld_reg[NR-1];
    assign m_tdata  = {st_reg[NR-1][95:64], st_reg[NR-1][127:96],
                       st_reg[NR-1][31:0],  st_reg[NR-1][63:32]};

endmodule

// ===== tb/sv/tb_sm4_block_cipher_core.sv =====
module tb_sm4_block_cipher_core;

    // ------------------------------------------------------------------
    // Run parameters
    // ------------------------------------------------------------------
    localparam int unsigned PHASE_WORDS    = 370;   // random words per key setting
    localparam int unsigned HOLD_AT_WORD   = 900;   // input count that triggers the long hold
    localparam int unsigned HOLD_CYCLES    = 300;   // long receiver hold-off
    localparam int unsigned IDLE_PERCENT   = 33;
    localparam int unsigned WATCHDOG_LIMIT = 2000;  // cycles with no handshake of any kind
    localparam int unsigned MAX_REPORTS    = 10;

    // FK words XORed into the key before the schedule runs
    localparam logic [31:0] FK_0 = 32'ha3b1bac6;
    localparam logic [31:0] FK_1 = 32'h56aa3350;
    localparam logic [31:0] FK_2 = 32'h677d9197;
    localparam logic [31:0] FK_3 = 32'hb27022dc;

    // S-box, entry 0 in the top byte
    localparam logic [0:255][7:0] SUB_TABLE = {
        128'hd690e9fecce13db716b614c228fb2c05, 128'h2b679a762abe04c3aa44132649860699,
        128'h9c4250f491ef987a33540b43edcfac62, 128'he4b31ca9c908e89580df94fa758f3fa6,
        128'h4707a7fcf37317ba83593c19e6854fa8, 128'h686b81b27164da8bf8eb0f4b70569d35,
        128'h1e240e5e6358d1a225227c3b01217887, 128'hd40046579fd327524c3602e7a0c4c89e,
        128'heabf8ad240c738b5a3f7f2cef96115a1, 128'he0ae5da49b341a55ad933230f58cb1e3,
        128'h1df6e22e8266ca60c02923ab0d534e6f, 128'hd5db3745defd8e2f03ff6a726d6c5b51,
        128'h8d1baf92bbddbc7f11d95c411f105ad8, 128'h0ac13188a5cd7bbd2d74d012b8e5b4b0,
        128'h8969974a0c96777e65b9f109c56ec684, 128'h18f07dec3adc4d2079ee5f3ed7cb3948
    };

    typedef enum logic {
        CMD_ENCRYPT = 1'b0,
        CMD_DECRYPT = 1'b1
    } cipher_cmd_t;

    // one input word as the block sees it
    typedef struct packed {
        cipher_cmd_t cmd;
        logic [63:0] upper;     // bytes 0..7
        logic [63:0] lower;     // bytes 8..15
    } block_word_t;

    // one result word
    typedef struct packed {
        logic [63:0] upper;
        logic [63:0] lower;
    } cipher_out_t;

    // ------------------------------------------------------------------
    // DUT ports; every input known from time zero
    // ------------------------------------------------------------------
    logic         aclk     = 1'b0;
    logic         aresetn  = 1'b0;
    logic         psel     = 1'b0;
    logic         penable  = 1'b0;
    logic         pwrite   = 1'b0;
    logic [3:0]   paddr    = '0;
    logic [63:0]  pwdata   = '0;
    logic [63:0]  prdata;
    logic         pready;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [127:0] s_tdata  = '0;    // [63:0] block_upper, [127:64] block_lower
    logic         s_tuser  = 1'b0;  // [0] command
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [127:0] m_tdata;          // [63:0] result_upper, [127:64] result_lower

    sm4_block_cipher_core i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // ------------------------------------------------------------------
    // Cipher model state: key registers and the expanded round keys
    // ------------------------------------------------------------------
    logic [63:0] key_hi_model = '0;
    logic [63:0] key_lo_model = '0;
    logic [31:0] round_key_model [32];

    block_word_t blocks_to_send [$];    // filled by the sequencer, drained by the driver
    cipher_out_t expected_out   [$];    // predicted results, oldest first

    int unsigned n_queued      = 0;     // words handed to the driver
    int unsigned n_in          = 0;     // words accepted by the block
    int unsigned n_dec         = 0;     // of which decrypt
    int unsigned n_out         = 0;     // result words accepted from the block
    int unsigned n_faults      = 0;
    int unsigned n_key_writes  = 0;
    int unsigned idle_cycles   = 0;
    int unsigned hold_left     = 0;
    logic        hold_done     = 1'b0;
    logic        no_gaps       = 1'b0;  // both sides stream without idling

    block_word_t taken;
    block_word_t next_blk;
    cipher_out_t seen;
    cipher_out_t want;

    function automatic logic [31:0] rotl32(input logic [31:0] x, input int unsigned n);
        return (x << n) | (x >> (32 - n));
    endfunction

    function automatic logic [31:0] subst_word(input logic [31:0] a);
        return {SUB_TABLE[a[31:24]], SUB_TABLE[a[23:16]],
                SUB_TABLE[a[15:8]], SUB_TABLE[a[7:0]]};
    endfunction

    // key schedule from the current key register pair
    function automatic void expand_round_keys();
        logic [31:0] k [4];
        logic [31:0] ck;
        logic [31:0] t;
        logic [31:0] n;
        k[0] = key_hi_model[63:32] ^ FK_0;
        k[1] = key_hi_model[31:0]  ^ FK_1;
        k[2] = key_lo_model[63:32] ^ FK_2;
        k[3] = key_lo_model[31:0]  ^ FK_3;
        for (int i = 0; i < 32; i++) begin
            // CK byte j of round i is (4i+j)*7 mod 256
            ck = '0;
            for (int j = 0; j < 4; j++) begin
                ck = {ck[23:0], 8'((4 * i + j) * 7)};
            end
            t = subst_word(k[1] ^ k[2] ^ k[3] ^ ck);
            n = k[0] ^ t ^ rotl32(t, 13) ^ rotl32(t, 23);
            round_key_model[i] = n;
            k[0] = k[1];
            k[1] = k[2];
            k[2] = k[3];
            k[3] = n;
        end
    endfunction

    // 32 data rounds; decrypt walks the round keys backwards
    function automatic cipher_out_t sm4_cipher(input block_word_t b);
        logic [31:0] x [4];
        logic [31:0] t;
        logic [31:0] n;
        logic [31:0] rk;
        cipher_out_t r;
        x[0] = b.upper[63:32];
        x[1] = b.upper[31:0];
        x[2] = b.lower[63:32];
        x[3] = b.lower[31:0];
        for (int i = 0; i < 32; i++) begin
            rk = (b.cmd == CMD_DECRYPT) ? round_key_model[31 - i] : round_key_model[i];
            t  = subst_word(x[1] ^ x[2] ^ x[3] ^ rk);
            n  = x[0] ^ t ^ rotl32(t, 2) ^ rotl32(t, 10) ^ rotl32(t, 18) ^ rotl32(t, 24);
            x[0] = x[1];
            x[1] = x[2];
            x[2] = x[3];
            x[3] = n;
        end
        // final reverse of the word order
        r.upper = {x[3], x[2]};
        r.lower = {x[1], x[0]};
        return r;
    endfunction

    task automatic report_fault(input string what, input logic [127:0] exp_val,
                                input logic [127:0] act_val);
        n_faults++;
        if (n_faults <= MAX_REPORTS) begin
            $display("MISMATCH %s: expected %h, got %h", what, exp_val, act_val);
        end
    endtask

    // ------------------------------------------------------------------
    // Clock and reset
    // ------------------------------------------------------------------
    initial begin
        forever #10 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Input driver: offers queued words, idles at random, holds a word
    // steady while the block back-pressures. Prediction is made here at
    // the accepting edge, from what the block actually took.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                taken.cmd   = cipher_cmd_t'(s_tuser);
                taken.upper = s_tdata[63:0];
                taken.lower = s_tdata[127:64];
                expected_out.push_back(sm4_cipher(taken));
                n_in  <= n_in + 1;
                n_dec <= n_dec + 32'(taken.cmd == CMD_DECRYPT);
            end
            // free to change the bus only once the current word has gone
            if (!s_tvalid || s_tready) begin
                if (blocks_to_send.size() != 0 &&
                    (no_gaps || $urandom_range(99) >= IDLE_PERCENT)) begin
                    next_blk = blocks_to_send.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {next_blk.lower, next_blk.upper};
                    s_tuser  <= next_blk.cmd;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver ready: random stalls, plus one long hold-off once enough
    // words have gone in, so the pipe fills and s_tready drops
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else if (!hold_done && n_in >= HOLD_AT_WORD) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= no_gaps || ($urandom_range(99) >= IDLE_PERCENT);
        end
    end

    // ------------------------------------------------------------------
    // Result monitor: each accepted word against the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            n_out <= n_out + 1;
            seen.upper = m_tdata[63:0];
            seen.lower = m_tdata[127:64];
            if (expected_out.size() == 0) begin
                report_fault("unexpected result word", '0, seen);
            end else begin
                want = expected_out.pop_front();
                if (seen.upper !== want.upper) begin
                    report_fault("result_upper", 128'(want.upper), 128'(seen.upper));
                end
                if (seen.lower !== want.lower) begin
                    report_fault("result_lower", 128'(want.lower), 128'(seen.lower));
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: any handshake (stream or APB) counts as progress
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no progress for %0d cycles, %0d of %0d results in",
                     idle_cycles, n_out, n_queued);
            $display("CHECK FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sequencer helpers
    // ------------------------------------------------------------------

    // APB write of a key register, then read it back
    task automatic set_key_reg(input logic idx, input logic [63:0] val);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        // register taken at this edge; round keys re-expand from the pair
        if (idx == sm4_pkg::REG_KEY_UPPER) begin
            key_hi_model = val;
        end else begin
            key_lo_model = val;
        end
        expand_round_keys();
        n_key_writes++;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (prdata !== val) begin
            report_fault(idx == sm4_pkg::REG_KEY_UPPER ? "key_upper readback"
                                                       : "key_lower readback",
                         128'(val), 128'(prdata));
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic push_block(input cipher_cmd_t cmd, input logic [63:0] upper,
                              input logic [63:0] lower);
        block_word_t b;
        b.cmd   = cmd;
        b.upper = upper;
        b.lower = lower;
        blocks_to_send.push_back(b);
        n_queued++;
    endtask

    // mostly random blocks; some round trips (the opposite operation on what
    // the first would give) and some fixed bit patterns
    function automatic block_word_t random_block();
        block_word_t b;
        cipher_out_t ct;
        int unsigned pick;
        int unsigned bitpos;
        pick    = $urandom_range(99);
        bitpos  = $urandom_range(127);
        b.cmd   = cipher_cmd_t'($urandom_range(1));
        b.upper = {$urandom, $urandom};
        b.lower = {$urandom, $urandom};
        if (pick >= 70 && pick < 85) begin
            ct      = sm4_cipher(b);
            b.cmd   = (b.cmd == CMD_ENCRYPT) ? CMD_DECRYPT : CMD_ENCRYPT;
            b.upper = ct.upper;
            b.lower = ct.lower;
        end else if (pick >= 85) begin
            case ($urandom_range(3))
                0:       {b.upper, b.lower} = '0;
                1:       {b.upper, b.lower} = '1;
                2:       {b.upper, b.lower} = 128'b1 << bitpos;
                default: {b.upper, b.lower} = ~(128'b1 << bitpos);
            endcase
        end
        return b;
    endfunction

    // wait for every queued word's result, then a short settle
    task automatic drain();
        while (n_out < n_queued) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic run_random(input int unsigned count);
        repeat (count) begin
            blocks_to_send.push_back(random_block());
            n_queued++;
        end
        drain();
    endtask

    // ------------------------------------------------------------------
    // Sequencer: reset, directed words, then random phases under a
    // series of keys. Keys change only with the pipe empty.
    // ------------------------------------------------------------------
    initial begin
        expand_round_keys();            // reset key is all zeros
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // reset key: extremes of the block, both directions
        push_block(CMD_ENCRYPT, '0, '0);
        push_block(CMD_DECRYPT, '0, '0);
        push_block(CMD_ENCRYPT, '1, '1);
        push_block(CMD_DECRYPT, '1, '1);
        drain();

        // standard key; the standard vector both ways, then patterns
        set_key_reg(sm4_pkg::REG_KEY_UPPER, 64'h0123456789abcdef);
        set_key_reg(sm4_pkg::REG_KEY_LOWER, 64'hfedcba9876543210);
        push_block(CMD_ENCRYPT, 64'h0123456789abcdef, 64'hfedcba9876543210);
        push_block(CMD_DECRYPT, 64'h681edf34d206965e, 64'h86b3e94f536e4246);
        push_block(CMD_ENCRYPT, '0, '0);
        push_block(CMD_ENCRYPT, '1, '1);
        push_block(CMD_DECRYPT, {16{4'h5}}, {16{4'h5}});
        push_block(CMD_ENCRYPT, {16{4'ha}}, {16{4'ha}});
        push_block(CMD_ENCRYPT, 64'h8000000000000000, '0);
        push_block(CMD_DECRYPT, '0, 64'h1);
        push_block(CMD_ENCRYPT, '1, '0);
        push_block(CMD_DECRYPT, '0, '1);
        drain();

        // all-ones key
        set_key_reg(sm4_pkg::REG_KEY_UPPER, '1);
        set_key_reg(sm4_pkg::REG_KEY_LOWER, '1);
        run_random(PHASE_WORDS);

        // random key, both sides streaming with no idle cycles
        set_key_reg(sm4_pkg::REG_KEY_UPPER, {$urandom, $urandom});
        set_key_reg(sm4_pkg::REG_KEY_LOWER, {$urandom, $urandom});
        no_gaps <= 1'b1;
        run_random(PHASE_WORDS);
        no_gaps <= 1'b0;

        // lower half only rewritten; the long receiver hold falls in here
        set_key_reg(sm4_pkg::REG_KEY_LOWER, {$urandom, $urandom});
        run_random(PHASE_WORDS);

        // mixed extremes
        set_key_reg(sm4_pkg::REG_KEY_UPPER, '0);
        set_key_reg(sm4_pkg::REG_KEY_LOWER, '1);
        run_random(PHASE_WORDS);

        // upper half only rewritten
        set_key_reg(sm4_pkg::REG_KEY_UPPER, {$urandom, $urandom});
        run_random(PHASE_WORDS);

        // let any stray words surface before the verdict
        repeat (40) @(posedge aclk);
        if (expected_out.size() != 0) begin
            $display("%0d predicted result words never arrived", expected_out.size());
            n_faults += expected_out.size();
        end

        $display("Run covered %0d cipher words (%0d decrypt) over %0d key register writes,",
                 n_in, n_dec, n_key_writes);
        $display("zero, all-ones and mixed keys; %0d results checked, %0d faults.",
                 n_out, n_faults);
        if (n_faults == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
